[hw/rtl/utlm_pkg.sv]
`default_nettype none

package utlm_pkg;

	// Field and register widths.
	localparam int TIMER_BITS  = 16;
	localparam int SAMPLE_BITS = 10;
	localparam int PULSE_W     = 15;
	localparam int HEIGHT_W    = 9;
	localparam int PCT_W       = 7;
	localparam int DIST_W      = 10;
	localparam int TENTHS_W    = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;

	// Shared divider geometry: a 20-bit dividend over a 10-bit divisor,
	// two quotient bits per cycle.
	localparam int DIV_W      = 20;
	localparam int DVS_W      = 10;
	localparam int DIV_RADIX  = 2;
	localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [DVS_W-1:0]    US_PER_CM    = DVS_W'(58);
	localparam logic [DIV_W-1:0]    TENTHS_SCALE = DIV_W'(2000);
	localparam logic [TENTHS_W-1:0] TENTHS_FULL  = TENTHS_W'(1000);
	localparam logic [PCT_W-1:0]    PCT_SCALE    = PCT_W'(100);

	// Command codes.
	localparam logic [1:0] CMD_REARM  = 2'd0;
	localparam logic [1:0] CMD_ECHO   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_EMPTY    = 2'd0;
	localparam logic [1:0] STAT_HALF     = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_CONTAM   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CONTAM    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = CFG_IDX_W'(5);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/utlm_div.sv]
`default_nettype none

// Restoring divider, DIV_RADIX quotient bits per cycle. The divisor must be nonzero.
module utlm_div
	import utlm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [DIV_W-1:0]     quo_next;
	logic [DVS_W-1:0]     rem_next;

	always_comb begin
		logic [DVS_W:0] trial;
		quo_next = quo_q;
		rem_next = rem_q;
		for (int k = 0; k < DIV_RADIX; k++) begin
			trial    = {rem_next, quo_next[DIV_W-1]};
			quo_next = {quo_next[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial       = trial - {1'b0, dvs_q};
				quo_next[0] = 1'b1;
			end
			rem_next = trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[hw/rtl/ultrasonic_tank_level_monitor_core.sv]
`default_nettype none

// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    cmd, capture_time, water_sample
// output   out        out_valid / out_stall  distance, level_tenths, status, alert,
//                                            red_on, yellow_on, green_on, buzzer_on,
//                                            measurement_done
// config   in         cfg_we                 cfg_index, cfg_data
//
// Every event passes through the level stage before its result is offered; an accepted
// echo pulse is first converted to centimetres, and an event at zero height skips the
// level division. The shared divider serves both divisions, microseconds over 58 and
// the level, and retires two quotient bits per cycle. in_stall stays high from a transfer
// until the result is in the output register; a stalled output holds the block in its
// final state. Reset restores every default.

module ultrasonic_tank_level_monitor_core
	import utlm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             cmd,
	input  wire logic [TIMER_BITS-1:0]  capture_time,
	input  wire logic [SAMPLE_BITS-1:0] water_sample,

	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [DIST_W-1:0]           distance,
	output logic [TENTHS_W-1:0]         level_tenths,
	output logic [1:0]                  status,
	output logic                        alert,
	output logic                        red_on,
	output logic                        yellow_on,
	output logic                        green_on,
	output logic                        buzzer_on,
	output logic                        measurement_done,

	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_LVL,
		S_LDIV,
		S_EMIT
	} state_t;

	// Configuration registers.
	logic [HEIGHT_W-1:0]    height_q;
	logic [PCT_W-1:0]       overflow_pct_q;
	logic [PCT_W-1:0]       empty_pct_q;
	logic [SAMPLE_BITS-1:0] contam_limit_q;
	logic [PULSE_W-1:0]     min_pulse_q;
	logic [PULSE_W-1:0]     max_pulse_q;

	// Measurement state.
	state_t                 state_q;
	logic                   awaiting_fall_q;
	logic [TIMER_BITS-1:0]  rise_time_q;
	logic [DIST_W-1:0]      dist_q;
	logic [SAMPLE_BITS-1:0] water_q;
	logic                   done_flag_q;
	logic [HEIGHT_W-1:0]    lvl_q;
	logic [TENTHS_W-1:0]    tenths_q;
	div_req_t               div_req_q;
	div_rsp_t               div_rsp;

	// Output register.
	logic                   out_valid_q;
	logic [DIST_W-1:0]      distance_q;
	logic [TENTHS_W-1:0]    level_tenths_q;
	logic [1:0]             status_q;
	logic                   done_out_q;

	logic [TIMER_BITS-1:0]  ticks;
	logic [PULSE_W-1:0]     echo_us;
	logic                   pulse_ok;
	logic [HEIGHT_W-1:0]    lvl_next;
	logic [DIV_W-1:0]       lvl_dividend;
	logic [15:0]            lvl_pct;
	logic [15:0]            overflow_mark;
	logic [15:0]            empty_mark;
	logic [1:0]             status_next;
	logic                   out_free;

	// The configuration port writes one register per enabled edge; unknown
	// indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q       <= HEIGHT_W'(15);
			overflow_pct_q <= PCT_W'(50);
			empty_pct_q    <= PCT_W'(5);
			contam_limit_q <= SAMPLE_BITS'(100);
			min_pulse_q    <= PULSE_W'(150);
			max_pulse_q    <= PULSE_W'(23500);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEIGHT:    height_q       <= cfg_data[HEIGHT_W-1:0];
				REG_OVERFLOW:  overflow_pct_q <= cfg_data[PCT_W-1:0];
				REG_EMPTY:     empty_pct_q    <= cfg_data[PCT_W-1:0];
				REG_CONTAM:    contam_limit_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_MIN_PULSE: min_pulse_q    <= cfg_data[PULSE_W-1:0];
				REG_MAX_PULSE: max_pulse_q    <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// The timer wraps, so the pulse width is the difference modulo the timer
	// range; the timer ticks twice per microsecond.
	assign ticks    = capture_time - rise_time_q;
	assign echo_us  = ticks[TIMER_BITS-1:1];
	assign pulse_ok = (echo_us >= min_pulse_q) && (echo_us <= max_pulse_q);

	// Liquid height is the container height minus the distance, floored at zero.
	assign lvl_next = (dist_q >= {1'b0, height_q}) ? '0
	                : height_q - dist_q[HEIGHT_W-1:0];

	// Rounded tenths of a percent: (2000 * L + H) / (2 * H).
	assign lvl_dividend = DIV_W'(lvl_next) * TENTHS_SCALE + DIV_W'(height_q);

	// Status compares the exact percentage by cross-multiplying with the height.
	assign lvl_pct       = 16'(lvl_q) * 16'(PCT_SCALE);
	assign overflow_mark = 16'(overflow_pct_q) * 16'(height_q);
	assign empty_mark    = 16'(empty_pct_q) * 16'(height_q);

	always_comb begin
		if (water_q > contam_limit_q) begin
			status_next = STAT_CONTAM;
		end else if (lvl_pct >= overflow_mark) begin
			status_next = STAT_OVERFLOW;
		end else if (lvl_pct > empty_mark) begin
			status_next = STAT_HALF;
		end else begin
			status_next = STAT_EMPTY;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			awaiting_fall_q <= 1'b0;
			rise_time_q     <= '0;
			dist_q          <= '0;
			water_q         <= '0;
			done_flag_q     <= 1'b0;
			lvl_q           <= '0;
			tenths_q        <= '0;
			div_req_q       <= '0;
			out_valid_q     <= 1'b0;
			distance_q      <= '0;
			level_tenths_q  <= '0;
			status_q        <= STAT_EMPTY;
			done_out_q      <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LVL;
						case (cmd)
							CMD_REARM: begin
								awaiting_fall_q <= 1'b0;
								done_flag_q     <= 1'b0;
							end
							CMD_ECHO: begin
								if (!awaiting_fall_q) begin
									rise_time_q     <= capture_time;
									awaiting_fall_q <= 1'b1;
								end else begin
									awaiting_fall_q <= 1'b0;
									done_flag_q     <= 1'b1;
									if (pulse_ok) begin
										div_req_q.start    <= 1'b1;
										div_req_q.dividend <= DIV_W'(echo_us);
										div_req_q.divisor  <= US_PER_CM;
										state_q            <= S_DIST;
									end else begin
										// A rejected echo reads as zero distance, i.e. full.
										dist_q <= '0;
									end
								end
							end
							CMD_SAMPLE: begin
								water_q <= water_sample;
							end
							default: ;
						endcase
					end
				end
				S_DIST: begin
					if (div_rsp.done) begin
						dist_q  <= div_rsp.quotient[DIST_W-1:0];
						state_q <= S_LVL;
					end
				end
				S_LVL: begin
					lvl_q <= lvl_next;
					if (height_q == '0) begin
						tenths_q <= '0;
						state_q  <= S_EMIT;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= lvl_dividend;
						div_req_q.divisor  <= DVS_W'({height_q, 1'b0});
						state_q            <= S_LDIV;
					end
				end
				S_LDIV: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient > DIV_W'(TENTHS_FULL)) begin
							tenths_q <= TENTHS_FULL;
						end else begin
							tenths_q <= div_rsp.quotient[TENTHS_W-1:0];
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// The result waits here until the output register is free.
					if (out_free) begin
						out_valid_q    <= 1'b1;
						distance_q     <= dist_q;
						level_tenths_q <= tenths_q;
						status_q       <= status_next;
						done_out_q     <= done_flag_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	utlm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign distance         = distance_q;
	assign level_tenths     = level_tenths_q;
	assign status           = status_q;
	assign alert            = status_q inside {STAT_OVERFLOW, STAT_CONTAM};
	assign red_on           = (status_q == STAT_CONTAM);
	assign yellow_on        = (status_q == STAT_HALF);
	assign green_on         = (status_q == STAT_OVERFLOW);
	assign buzzer_on        = alert;
	assign measurement_done = done_out_q;

endmodule

`default_nettype wire
